FILE: sv/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

FILE: sv/cfla_pkg.sv
// Package for the chunk free-list allocator: codes, field widths, state type.
// No dependencies.
package cfla_pkg;

    // Request kinds
    localparam logic KIND_FREE  = 1'b0;
    localparam logic KIND_ALLOC = 1'b1;

    // Register index (paddr[2]) of the mode register
    localparam logic REG_ORDERED_MODE = 1'b0;

    // Fixed field widths
    localparam int INDEX_W  = 10;
    localparam int COUNT_W  = 11;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_F_START,
        S_F_WALK,
        S_F_SWEEP,
        S_F_LREAD,
        S_F_LWAIT,
        S_F_SPLICE,
        S_A_START,
        S_A_WALK,
        S_A_FIN,
        S_DONE
    } state_t;

endpackage

FILE: sv/cfla_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cfla_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/chunk_free_list_allocator.sv
// Top level of the chunk free-list allocator: sequencer, list head, mode register.
// Depends on cfla_pkg, cfla_ram and assert_macros.svh.
//
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------
//  req     | req_valid / req_stall | kind, first_index, run_length
//  rsp     | rsp_valid / rsp_stall | ok, granted_index, list_empty
//  cfg     | APB psel/penable      | paddr, pwdata, prdata, pready
//
// One request at a time; the free list lives in the next-link RAM and each walk
// step is one read of that RAM's read port (one node per cycle).
// Reset clears the list head (list empty), the state, the output valid and sets ordered mode;
// the link RAM needs no clearing. A new request is taken while the previous result waits in
// the output register; its result waits in the done state while that register is full and rsp_stall is high.
`include "assert_macros.svh"

module chunk_free_list_allocator #(
    parameter int NUM_CHUNKS = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic                            kind,
    input  logic [cfla_pkg::INDEX_W-1:0]    first_index,
    input  logic [cfla_pkg::COUNT_W-1:0]    run_length,
    // response channel
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic                            ok,
    output logic [cfla_pkg::INDEX_W-1:0]    granted_index,
    output logic                            list_empty,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cfla_pkg::PADDR_W-1:0]    paddr,
    input  logic [cfla_pkg::PDATA_W-1:0]    pwdata,
    output logic [cfla_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    localparam int LINK_W  = $clog2(NUM_CHUNKS + 1);
    localparam int ADDR_W  = $clog2(NUM_CHUNKS);
    localparam int IDX_W   = cfla_pkg::INDEX_W;
    localparam int CNT_W   = cfla_pkg::COUNT_W;
    localparam int CALC_W  = ((LINK_W > CNT_W) ? LINK_W : CNT_W) + 1;
    localparam logic [LINK_W-1:0] NIL      = LINK_W'(NUM_CHUNKS);
    localparam logic [CALC_W-1:0] POOL_END = CALC_W'(NUM_CHUNKS);

    cfla_pkg::state_t state_reg, state_next;

    logic                ordered_reg;
    logic [LINK_W-1:0]   head_reg, head_next;
    logic                kind_reg, kind_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [LINK_W-1:0]   prev_reg, prev_next;
    logic                prev_head_reg, prev_head_next;
    logic [LINK_W-1:0]   steps_reg, steps_next;
    logic [LINK_W-1:0]   iter_reg, iter_next;
    logic [LINK_W-1:0]   end_m1_reg, end_m1_next;
    logic [LINK_W-1:0]   run_first_reg, run_first_next;
    logic [LINK_W-1:0]   last_reg, last_next;
    logic [CNT_W-1:0]    remain_reg, remain_next;
    logic                res_ok_reg, res_ok_next;
    logic [IDX_W-1:0]    res_grant_reg, res_grant_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic                ok_reg, ok_next;
    logic [IDX_W-1:0]    grant_reg, grant_next;
    logic                empty_reg, empty_next;

    // RAM port signals
    logic                ram_we, ram_re;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [LINK_W-1:0]   ram_wdata, ram_rdata;

    logic                req_take, rsp_take, rsp_load, cfg_write;
    logic [LINK_W-1:0]   free_first;
    logic [CALC_W-1:0]   run_sum, run_end;
    logic [LINK_W-1:0]   end_m1;
    logic                head_valid, free_noop, f_take_head, f_take_rd, sweep_more;
    logic                a_bad, a_seq, count_one, remain_two, count_zero;

    // Assertion terms
    logic                req_started, in_done, rsp_blocked, rsp_failed, free_done;

    cfla_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NUM_CHUNKS)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshakes
    assign req_stall = (state_reg != cfla_pkg::S_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign rsp_take  = rsp_valid_reg && !rsp_stall;
    assign rsp_load  = (state_reg == cfla_pkg::S_DONE) && (!rsp_valid_reg || !rsp_stall);

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == cfla_pkg::REG_ORDERED_MODE);
    assign prdata    = (paddr[2] == cfla_pkg::REG_ORDERED_MODE)
                     ? {{(cfla_pkg::PDATA_W-1){1'b0}}, ordered_reg}
                     : '0;

    // Walk and range conditions
    assign free_first  = LINK_W'(idx_reg);
    assign count_zero  = (count_reg == '0);
    assign head_valid  = (head_reg < NIL);
    assign free_noop   = count_zero || (CALC_W'(idx_reg) >= POOL_END);
    assign run_sum     = CALC_W'(idx_reg) + CALC_W'(count_reg);
    assign run_end     = (run_sum > POOL_END) ? POOL_END : run_sum;
    assign end_m1      = LINK_W'(run_end - CALC_W'(1));
    assign f_take_head = head_valid && (CALC_W'(head_reg) <= CALC_W'(idx_reg));
    assign f_take_rd   = (ram_rdata < NIL) && (steps_reg < NIL)
                       && (CALC_W'(ram_rdata) <= CALC_W'(idx_reg));
    assign sweep_more  = (iter_reg < end_m1_reg);
    assign a_bad       = (steps_reg >= NIL) || (ram_rdata >= NIL);
    assign a_seq       = (CALC_W'(ram_rdata) == CALC_W'(last_reg) + CALC_W'(1));
    assign count_one   = (count_reg == CNT_W'(1));
    assign remain_two  = (remain_reg == CNT_W'(2));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cfla_pkg::S_IDLE:
            begin
                if (req_take)
                begin
                    state_next = (kind == cfla_pkg::KIND_ALLOC) ? cfla_pkg::S_A_START
                                                                : cfla_pkg::S_F_START;
                end
            end
            cfla_pkg::S_F_START:
            begin
                if (free_noop)
                    state_next = cfla_pkg::S_DONE;
                else if (ordered_reg && f_take_head)
                    state_next = cfla_pkg::S_F_WALK;
                else
                    state_next = cfla_pkg::S_F_SWEEP;
            end
            cfla_pkg::S_F_WALK:
            begin
                if (!f_take_rd)
                    state_next = cfla_pkg::S_F_SWEEP;
            end
            cfla_pkg::S_F_SWEEP:
            begin
                if (!sweep_more)
                    state_next = cfla_pkg::S_F_LREAD;
            end
            cfla_pkg::S_F_LREAD:  state_next = cfla_pkg::S_F_LWAIT;
            cfla_pkg::S_F_LWAIT:  state_next = cfla_pkg::S_F_SPLICE;
            cfla_pkg::S_F_SPLICE: state_next = cfla_pkg::S_DONE;
            cfla_pkg::S_A_START:
            begin
                if (count_zero || !head_valid)
                    state_next = cfla_pkg::S_DONE;
                else if (count_one)
                    state_next = cfla_pkg::S_A_FIN;
                else
                    state_next = cfla_pkg::S_A_WALK;
            end
            cfla_pkg::S_A_WALK:
            begin
                if (a_bad)
                    state_next = cfla_pkg::S_DONE;
                else if (a_seq && remain_two)
                    state_next = cfla_pkg::S_A_FIN;
            end
            cfla_pkg::S_A_FIN:    state_next = cfla_pkg::S_DONE;
            cfla_pkg::S_DONE:
            begin
                if (rsp_load)
                    state_next = cfla_pkg::S_IDLE;
            end
            default:              state_next = cfla_pkg::S_IDLE;
        endcase
    end

    // Datapath and RAM control
    always_comb
    begin
        head_next      = head_reg;
        kind_next      = kind_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        prev_next      = prev_reg;
        prev_head_next = prev_head_reg;
        steps_next     = steps_reg;
        iter_next      = iter_reg;
        end_m1_next    = end_m1_reg;
        run_first_next = run_first_reg;
        last_next      = last_reg;
        remain_next    = remain_reg;
        res_ok_next    = res_ok_reg;
        res_grant_next = res_grant_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        case (state_reg)
            cfla_pkg::S_IDLE:
            begin
                if (req_take)
                begin
                    kind_next      = kind;
                    idx_next       = first_index;
                    count_next     = run_length;
                    res_ok_next    = 1'b1;
                    res_grant_next = '0;
                end
            end
            // Free: set up the run and, in ordered mode, start the ordered walk at the head
            cfla_pkg::S_F_START:
            begin
                iter_next      = free_first;
                end_m1_next    = end_m1;
                steps_next     = '0;
                prev_head_next = 1'b1;
                if (!free_noop && ordered_reg && f_take_head)
                begin
                    prev_next      = head_reg;
                    prev_head_next = 1'b0;
                    steps_next     = LINK_W'(1);
                    ram_re         = 1'b1;
                    ram_raddr      = head_reg[ADDR_W-1:0];
                end
            end
            // One node per cycle until a larger index, nil or the step bound
            cfla_pkg::S_F_WALK:
            begin
                if (f_take_rd)
                begin
                    prev_next  = ram_rdata;
                    steps_next = steps_reg + LINK_W'(1);
                    ram_re     = 1'b1;
                    ram_raddr  = ram_rdata[ADDR_W-1:0];
                end
            end
            // Chain the run internally, one link per cycle
            cfla_pkg::S_F_SWEEP:
            begin
                if (sweep_more)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = iter_reg[ADDR_W-1:0];
                    ram_wdata = iter_reg + LINK_W'(1);
                    iter_next = iter_reg + LINK_W'(1);
                end
            end
            // Fetch the successor of the insert point after the sweep
            cfla_pkg::S_F_LREAD:
            begin
                if (!prev_head_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = prev_reg[ADDR_W-1:0];
                end
            end
            cfla_pkg::S_F_LWAIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = end_m1_reg[ADDR_W-1:0];
                ram_wdata = prev_head_reg ? head_reg : ram_rdata;
            end
            cfla_pkg::S_F_SPLICE:
            begin
                if (prev_head_reg)
                begin
                    head_next = free_first;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = prev_reg[ADDR_W-1:0];
                    ram_wdata = free_first;
                end
            end
            // Allocate: candidate run starts at the head
            cfla_pkg::S_A_START:
            begin
                prev_head_next = 1'b1;
                run_first_next = head_reg;
                last_next      = head_reg;
                remain_next    = count_reg;
                steps_next     = '0;
                if (count_zero || !head_valid)
                begin
                    res_ok_next = 1'b0;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = head_reg[ADDR_W-1:0];
                end
            end
            // Extend the run or restart it at the node that broke it
            cfla_pkg::S_A_WALK:
            begin
                if (a_bad)
                begin
                    res_ok_next = 1'b0;
                end
                else
                begin
                    steps_next = steps_reg + LINK_W'(1);
                    last_next  = ram_rdata;
                    ram_re     = 1'b1;
                    ram_raddr  = ram_rdata[ADDR_W-1:0];
                    if (a_seq)
                    begin
                        remain_next = remain_reg - CNT_W'(1);
                    end
                    else
                    begin
                        prev_next      = last_reg;
                        prev_head_next = 1'b0;
                        run_first_next = ram_rdata;
                        remain_next    = count_reg;
                    end
                end
            end
            // Unlink the run: predecessor takes the successor of its last node
            cfla_pkg::S_A_FIN:
            begin
                if (prev_head_reg)
                begin
                    head_next = ram_rdata;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = prev_reg[ADDR_W-1:0];
                    ram_wdata = ram_rdata;
                end
                res_grant_next = IDX_W'(run_first_reg);
            end
            cfla_pkg::S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Output register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        ok_next        = ok_reg;
        grant_next     = grant_reg;
        empty_next     = empty_reg;
        if (rsp_take)
            rsp_valid_next = 1'b0;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
            ok_next        = res_ok_reg;
            grant_next     = res_grant_reg;
            empty_next     = (head_reg == NIL);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cfla_pkg::S_IDLE;
            head_reg      <= NIL;
            ordered_reg   <= 1'b1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_write)
                ordered_reg <= pwdata[0];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        idx_reg       <= idx_next;
        count_reg     <= count_next;
        prev_reg      <= prev_next;
        prev_head_reg <= prev_head_next;
        steps_reg     <= steps_next;
        iter_reg      <= iter_next;
        end_m1_reg    <= end_m1_next;
        run_first_reg <= run_first_next;
        last_reg      <= last_next;
        remain_reg    <= remain_next;
        res_ok_reg    <= res_ok_next;
        res_grant_reg <= res_grant_next;
        ok_reg        <= ok_next;
        grant_reg     <= grant_next;
        empty_reg     <= empty_next;
    end

    assign rsp_valid     = rsp_valid_reg;
    assign ok            = ok_reg;
    assign granted_index = grant_reg;
    assign list_empty    = empty_reg;

    // Assertion terms
    assign req_started = (state_reg == cfla_pkg::S_F_START)
                       || (state_reg == cfla_pkg::S_A_START);
    assign in_done     = (state_reg == cfla_pkg::S_DONE);
    assign rsp_blocked = rsp_valid_reg && rsp_stall;
    assign rsp_failed  = rsp_valid_reg && !ok_reg;
    assign free_done   = in_done && (kind_reg == cfla_pkg::KIND_FREE);

    // Assertions
    `ASSERT_PROP(a_req_starts, req_take |=> req_started, "accepted item did not start a request")
    `ASSERT_NEVER(a_ram_rw, ram_we && ram_re, "link RAM read and written in one cycle")
    `ASSERT_PROP(a_done_hold, (in_done && rsp_blocked) |=> in_done, "result lost under stall")
    `ASSERT_PROP(a_fail_zero, rsp_failed |-> (grant_reg == '0), "failure with nonzero index")
    `ASSERT_PROP(a_free_ok, free_done |-> res_ok_reg, "free request reports failure")

endmodule

FILE: sim/chunk_free_list_allocator_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for chunk_free_list_allocator: directed and random
// free/allocate traffic, checked against an in-bench free-list model.
// Depends on cfla_pkg and the allocator RTL.

module chunk_free_list_allocator_test;

    localparam int IDX_W        = cfla_pkg::INDEX_W;
    localparam int CNT_W        = cfla_pkg::COUNT_W;
    localparam int ADR_W        = cfla_pkg::PADDR_W;
    localparam int DAT_W        = cfla_pkg::PDATA_W;
    localparam int POOL_SIZE    = 1024;
    localparam int NIL_REF      = POOL_SIZE;
    localparam int HEAD_SLOT    = POOL_SIZE + 1;
    localparam int MAX_COUNT    = (1 << CNT_W) - 1;
    localparam int LIST_CAP     = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 16;
    localparam int TAIL_CYCLES  = 2100;
    localparam int RUN_LIMIT_NS = 40_000_000;

    localparam logic [ADR_W-1:0] MODE_ADDR = {cfla_pkg::REG_ORDERED_MODE, 2'b00};

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] granted;
        logic             empty;
    } pool_reply_t;

    // DUT connections, all inputs known from time zero
    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 req_valid   = 1'b0;
    logic                 req_stall;
    logic                 kind        = cfla_pkg::KIND_FREE;
    logic [IDX_W-1:0]     first_index = '0;
    logic [CNT_W-1:0]     run_length  = '0;
    logic                 rsp_valid;
    logic                 rsp_stall   = 1'b0;
    logic                 ok;
    logic [IDX_W-1:0]     granted_index;
    logic                 list_empty;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [ADR_W-1:0]     paddr       = '0;
    logic [DAT_W-1:0]     pwdata      = '0;
    logic [DAT_W-1:0]     prdata;
    logic                 pready;

    // Free-list model state
    int   free_next [POOL_SIZE];
    int   free_head      = NIL_REF;
    logic ordered_shadow = 1'b1;

    pool_reply_t pending_replies [$];
    int          mismatches    = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    logic        hold_on       = 1'b0;

    chunk_free_list_allocator #(
        .NUM_CHUNKS (POOL_SIZE)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .kind          (kind),
        .first_index   (first_index),
        .run_length    (run_length),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .ok            (ok),
        .granted_index (granted_index),
        .list_empty    (list_empty),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 clk = ~clk;

    // ---------------------------------------------------------------
    // Free-list model
    // ---------------------------------------------------------------

    function automatic int read_link(input int p);
        if (p == HEAD_SLOT)
            return free_head;
        if (p < POOL_SIZE)
            return free_next[p];
        return NIL_REF;
    endfunction

    function automatic void write_link(input int p, input int v);
        if (p == HEAD_SLOT)
            free_head = v;
        else if (p < POOL_SIZE)
            free_next[p] = v;
    endfunction

    // Last listed node not above idx, bounded walk
    function automatic int splice_point(input int idx);
        int prev;
        int c;
        int steps;
        prev  = HEAD_SLOT;
        c     = free_head;
        steps = 0;
        while (c < POOL_SIZE && steps < POOL_SIZE)
        begin
            if (c > idx)
                break;
            prev = c;
            c    = read_link(c);
            steps++;
        end
        return prev;
    endfunction

    // Link a run of chunks into the list (clipped at pool end)
    function automatic void link_run(input int first, input int count);
        int run_end;
        int prev;
        int i;
        if (count == 0 || first >= POOL_SIZE)
            return;
        run_end = first + count;
        if (run_end > POOL_SIZE)
            run_end = POOL_SIZE;
        prev = ordered_shadow ? splice_point(first) : HEAD_SLOT;
        for (i = first; i + 1 < run_end; i++)
            free_next[i] = i + 1;
        free_next[run_end - 1] = read_link(prev);
        write_link(prev, first);
    endfunction

    // Search for count list-adjacent consecutive chunks and unlink them
    function automatic logic take_run(input int count, output int granted);
        int   prev;
        int   first;
        int   last;
        int   steps;
        int   n;
        int   nx;
        logic found;
        prev    = HEAD_SLOT;
        first   = free_head;
        last    = first;
        steps   = 0;
        found   = 1'b0;
        granted = 0;
        if (count == 0)
            return 1'b0;
        while (!found)
        begin
            n = count;
            if (first >= POOL_SIZE)
                return 1'b0;
            last  = first;
            found = 1'b1;
            while (n > 1)
            begin
                nx = read_link(last);
                steps++;
                if (steps > POOL_SIZE)
                    return 1'b0;
                if (nx == NIL_REF || nx != last + 1)
                begin
                    prev  = last;
                    first = nx;
                    found = 1'b0;
                    break;
                end
                last = nx;
                n--;
            end
        end
        write_link(prev, read_link(last));
        granted = first;
        return 1'b1;
    endfunction

    function automatic pool_reply_t apply_request(input logic k, input int fi, input int cnt);
        pool_reply_t r;
        int          g;
        r.ok      = 1'b1;
        r.granted = '0;
        if (k == cfla_pkg::KIND_FREE)
            link_run(fi, cnt);
        else
        begin
            r.ok = take_run(cnt, g);
            if (r.ok)
                r.granted = g[IDX_W-1:0];
        end
        r.empty = (free_head == NIL_REF);
        return r;
    endfunction

    // Chunks currently reachable from the head
    function automatic logic [POOL_SIZE-1:0] listed_map();
        logic [POOL_SIZE-1:0] m;
        int                   c;
        int                   steps;
        m     = '0;
        c     = free_head;
        steps = 0;
        while (c < POOL_SIZE && steps < POOL_SIZE)
        begin
            m[c] = 1'b1;
            c    = free_next[c];
            steps++;
        end
        return m;
    endfunction

    // Mostly short runs, a few longer ones
    function automatic int pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return 1;
        if (r < 80)
            return $urandom_range(2, 4);
        if (r < 98)
            return $urandom_range(5, 16);
        return $urandom_range(17, 64);
    endfunction

    // ---------------------------------------------------------------
    // Result checker and receiver stall
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin : check_results
        pool_reply_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("result with no request pending: ok %0d granted_index %0d",
                       ok, granted_index);
                mismatches++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (ok !== want.ok)
                begin
                    $error("ok: expected %0d, actual %0d", want.ok, ok);
                    mismatches++;
                end
                if (granted_index !== want.granted)
                begin
                    $error("granted_index: expected %0d, actual %0d",
                           want.granted, granted_index);
                    mismatches++;
                end
                if (list_empty !== want.empty)
                begin
                    $error("list_empty: expected %0d, actual %0d", want.empty, list_empty);
                    mismatches++;
                end
            end
        end
        rsp_stall <= hold_on || ($urandom_range(99) < stall_pct);
    end

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------

    // Offer one item, wait for it to be taken, record the expected reply
    task automatic send_request(input logic k, input logic [IDX_W-1:0] fi,
                                input logic [CNT_W-1:0] cnt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid   <= 1'b1;
        kind        <= k;
        first_index <= fi;
        run_length  <= cnt;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pending_replies.push_back(apply_request(k, int'(fi), int'(cnt)));
    endtask

    // Drop valid and let every outstanding reply come back
    task automatic wait_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [ADR_W-1:0] addr, input logic [DAT_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [ADR_W-1:0] addr, output logic [DAT_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_mode(input logic m);
        logic [DAT_W-1:0] readback;
        apb_read(MODE_ADDR, readback);
        if (readback !== DAT_W'(m))
        begin
            $error("ordered_mode: expected %0d, actual %0d", m, readback);
            mismatches++;
        end
    endtask

    // Mode changes only with the block idle
    task automatic set_mode(input logic m);
        wait_idle();
        apb_write(MODE_ADDR, DAT_W'(m));
        ordered_shadow = m;
        check_mode(m);
    endtask

    // One random item: mostly well-formed frees of chunks not on the list,
    // allocations, some zero counts; broken traffic adds blind frees.
    task automatic random_request(input logic allow_broken);
        logic [POOL_SIZE-1:0] listed;
        int                   pick;
        int                   start;
        int                   avail;
        int                   cnt;
        int                   tries;
        pick   = $urandom_range(99);
        listed = listed_map();
        if (allow_broken && pick < 30)
            send_request(cfla_pkg::KIND_FREE, IDX_W'($urandom_range(POOL_SIZE - 1)),
                         CNT_W'($urandom_range(1, 8)));
        else if (pick < 4)
            send_request(logic'($urandom_range(1)), IDX_W'($urandom_range(POOL_SIZE - 1)),
                         '0);
        else if (pick < 52 && $countones(listed) < LIST_CAP)
        begin
            start = $urandom_range(POOL_SIZE - 1);
            tries = 0;
            while (listed[start] && tries < POOL_SIZE)
            begin
                start = (start + 1) % POOL_SIZE;
                tries++;
            end
            avail = 0;
            while (start + avail < POOL_SIZE && !listed[start + avail])
                avail++;
            cnt = pick_count();
            if (cnt > avail)
                cnt = avail;
            // run reaching the pool end: sometimes overshoot so it gets clipped
            if (start + avail == POOL_SIZE && $urandom_range(9) == 0)
                cnt = avail + $urandom_range(1, MAX_COUNT - avail);
            send_request(cfla_pkg::KIND_FREE, IDX_W'(start), CNT_W'(cnt));
        end
        else
        begin
            cnt = ($urandom_range(49) == 0) ? $urandom_range(MAX_COUNT) : pick_count();
            send_request(cfla_pkg::KIND_ALLOC, IDX_W'($urandom_range(POOL_SIZE - 1)),
                         CNT_W'(cnt));
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    task automatic test_mode_register();
        check_mode(1'b1);
        set_mode(1'b0);
        set_mode(1'b1);
    endtask

    task automatic test_directed_cases();
        send_idle_pct = 0;
        stall_pct    <= 0;
        set_mode(1'b1);
        // empty list and zero counts
        send_request(cfla_pkg::KIND_ALLOC, '0, CNT_W'(1));
        send_request(cfla_pkg::KIND_ALLOC, '1, '0);
        send_request(cfla_pkg::KIND_FREE, IDX_W'(5), '0);
        // ordered splice ahead of a higher index, non-adjacent pair
        send_request(cfla_pkg::KIND_FREE, '1, CNT_W'(1));
        send_request(cfla_pkg::KIND_FREE, '0, CNT_W'(1));
        send_request(cfla_pkg::KIND_ALLOC, '0, CNT_W'(2));
        send_request(cfla_pkg::KIND_ALLOC, '0, CNT_W'(1));
        send_request(cfla_pkg::KIND_ALLOC, '0, CNT_W'(1));
        // run past the pool end is clipped, then fill the whole pool
        send_request(cfla_pkg::KIND_FREE, IDX_W'(1000), '1);
        send_request(cfla_pkg::KIND_FREE, '0, CNT_W'(1000));
        send_request(cfla_pkg::KIND_ALLOC, '0, '1);
        send_request(cfla_pkg::KIND_ALLOC, '0, CNT_W'(POOL_SIZE));
        send_request(cfla_pkg::KIND_FREE, IDX_W'(512), CNT_W'(1));
        send_request(cfla_pkg::KIND_FREE, IDX_W'(511), CNT_W'(1));
        send_request(cfla_pkg::KIND_ALLOC, '0, CNT_W'(2));
        // head insertion, search skips a short run
        set_mode(1'b0);
        send_request(cfla_pkg::KIND_FREE, IDX_W'(100), CNT_W'(3));
        send_request(cfla_pkg::KIND_FREE, IDX_W'(50), CNT_W'(2));
        send_request(cfla_pkg::KIND_ALLOC, '0, CNT_W'(3));
        send_request(cfla_pkg::KIND_ALLOC, '0, CNT_W'(2));
        send_request(cfla_pkg::KIND_FREE, '1, CNT_W'(POOL_SIZE));
        send_request(cfla_pkg::KIND_ALLOC, '0, CNT_W'(1));
        // alternating index bit patterns
        send_request(cfla_pkg::KIND_FREE, IDX_W'(341), CNT_W'(1));
        send_request(cfla_pkg::KIND_FREE, IDX_W'(682), CNT_W'(1));
        send_request(cfla_pkg::KIND_ALLOC, IDX_W'(341), CNT_W'(1));
        send_request(cfla_pkg::KIND_ALLOC, IDX_W'(682), CNT_W'(1));
        wait_idle();
    endtask

    task automatic test_random_traffic(input int items, input int idle_pct,
                                       input int busy_pct, input logic mode);
        int i;
        set_mode(mode);
        send_idle_pct = idle_pct;
        stall_pct    <= busy_pct;
        for (i = 0; i < items; i++)
            random_request(1'b0);
        wait_idle();
    endtask

    // Receiver holds off while items keep coming, so the input stalls
    task automatic test_backpressure();
        int i;
        send_idle_pct = 0;
        stall_pct    <= 0;
        hold_on      <= 1'b1;
        fork
            begin
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_on <= 1'b0;
            end
        join_none
        for (i = 0; i < 40; i++)
            random_request(1'b0);
        wait_idle();
    endtask

    // Double frees corrupt the list; walks must stop at the bound
    task automatic test_corrupted_list();
        int i;
        send_idle_pct = 10;
        stall_pct    <= 10;
        set_mode(1'b1);
        for (i = 0; i < 40; i++)
            random_request(1'b1);
        set_mode(1'b0);
        for (i = 0; i < 40; i++)
            random_request(1'b1);
        wait_idle();
    endtask

    initial
    begin
        int i;
        for (i = 0; i < POOL_SIZE; i++)
            free_next[i] = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_mode_register();
        test_directed_cases();
        test_random_traffic(390, 0, 0, 1'b1);
        test_random_traffic(390, 76, 0, 1'b0);
        test_random_traffic(390, 0, 76, 1'b1);
        test_random_traffic(390, 25, 25, 1'b0);
        test_backpressure();
        test_corrupted_list();
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_replies.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
